// ===== rtl/ssf_pkg.sv =====
// ----------------------------------------------------------------------------
// ssf_pkg: shared types and helpers for the strut force core
// Beat structs, register indexes, saturating arithmetic and the tanh table
// generator used at elaboration.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int DATA_W        = 48;
  localparam int HALF_W        = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int MUL_LAT       = 3;
  localparam int FRAC_BITS_DEF = 24;
  localparam int TANH_DEPTH_DEF = 256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_SAG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRING_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_SCALE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_SLOPE = 3'd6;

  // bump stop region codes
  localparam logic [1:0] REGION_FREE  = 2'd0;
  localparam logic [1:0] REGION_UPPER = 2'd1;
  localparam logic [1:0] REGION_LOWER = 2'd2;

  localparam logic signed [DATA_W-1:0] MAX48 = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN48 = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [47:0] wheel_height;
    logic signed [47:0] wheel_radius;
    logic signed [47:0] wheel_vert_speed;
    logic signed [47:0] wheel_long_force;
    logic signed [47:0] wheel_lat_force;
    logic signed [47:0] wheel_roll_moment;
    logic signed [47:0] wheel_pitch_moment;
    logic signed [47:0] wheel_yaw_moment;
    logic signed [47:0] body_height;
    logic signed [47:0] body_vert_speed;
    logic signed [47:0] steer_angle;
  } ssf_in_t;

  typedef struct packed {
    logic signed [47:0] body_vert_force;
    logic signed [47:0] wheel_vert_force;
    logic signed [47:0] body_roll_moment;
    logic signed [47:0] body_pitch_moment;
    logic signed [47:0] body_yaw_moment;
    logic [1:0]         stop_region;
  } ssf_out_t;

  // saturating add and subtract
  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? MIN48 : MAX48;
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? MIN48 : MAX48;
    return s[DATA_W-1:0];
  endfunction

  // Q60 multiply, truncated
  function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // bitwise long division by a small count
  function automatic logic [63:0] div_small(input logic [63:0] v, input int n);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], v[b]};
      q   = {q[62:0], 1'b0};
      if (rem >= 64'(n)) begin
        rem  = rem - 64'(n);
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh table entry idx, y is 2^63 over the table depth
  function automatic logic [DATA_W-1:0] tanh_entry(input int frac, input logic [63:0] y,
                                                   input int idx);
    logic [63:0] one60;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] q;
    one60 = 64'd1 << 60;
    term  = one60;
    r     = one60;
    for (int n = 1; n <= 24; n++) begin
      term = div_small(mul60(term, y), n);
      if ((n % 2) == 1) r = r - term;
      else r = r + term;
    end
    e = one60;
    for (int i = 0; i < idx; i++) e = mul60(e, r);
    num = one60 - e;
    den = one60 + e;
    rem = num;
    q   = '0;
    for (int k = 0; k < frac; k++) begin
      rem = {rem[62:0], 1'b0};
      q   = {q[62:0], 1'b0};
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
    end
    return q[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/ssf_dly.sv =====
// ----------------------------------------------------------------------------
// ssf_dly: stall-aware delay line
// Carries side data alongside the pipeline for a fixed number of stages.
// ----------------------------------------------------------------------------
module ssf_dly #(
  parameter int W = 48,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [0:N-1];

  // shift chain, advances with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[N-1];

endmodule

// ===== rtl/ssf_mulq.sv =====
// ----------------------------------------------------------------------------
// ssf_mulq: pipelined fixed point multiply
// Three stages: magnitude, 24x24 partial products, sum with rounding to
// nearest (ties away from zero) and saturation to 48 bits.
// ----------------------------------------------------------------------------
module ssf_mulq
  import ssf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0] q
);

  localparam int PW = 2 * DATA_W;

  logic              neg1_r, neg2_r;
  logic [DATA_W-1:0] ua1_r, ub1_r;
  logic [DATA_W-1:0] pll_r, plh_r, phl_r, phh_r;
  logic signed [DATA_W-1:0] q_r;

  logic [PW-1:0]     prod;
  logic [PW-1:0]     shifted;
  logic [PW-1:0]     lim;
  logic [DATA_W-1:0] mag;

  // sum of partial products, round, saturate
  always_comb begin
    prod = {{DATA_W{1'b0}}, pll_r}
         + ({{DATA_W{1'b0}}, plh_r} << HALF_W)
         + ({{DATA_W{1'b0}}, phl_r} << HALF_W)
         + ({{DATA_W{1'b0}}, phh_r} << DATA_W)
         + (PW'(1) << (FRAC_BITS - 1));
    shifted = prod >> FRAC_BITS;
    lim     = neg2_r ? (PW'(1) << (DATA_W - 1)) : ((PW'(1) << (DATA_W - 1)) - PW'(1));
    mag     = (shifted > lim) ? lim[DATA_W-1:0] : shifted[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[DATA_W-1] ^ b[DATA_W-1];
      ua1_r  <= a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
      ub1_r  <= b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
      neg2_r <= neg1_r;
      pll_r  <= ua1_r[HALF_W-1:0]      * ub1_r[HALF_W-1:0];
      plh_r  <= ua1_r[HALF_W-1:0]      * ub1_r[DATA_W-1:HALF_W];
      phl_r  <= ua1_r[DATA_W-1:HALF_W] * ub1_r[HALF_W-1:0];
      phh_r  <= ua1_r[DATA_W-1:HALF_W] * ub1_r[DATA_W-1:HALF_W];
      q_r    <= neg2_r ? -$signed(mag) : $signed(mag);
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/suspension_strut_force_core.sv =====
// throughput: one beat per cycle; the whole pipeline holds while the output
// register is full and stalled, set by the chain of pipelined multipliers
// reset: synchronous active-low rst_n clears the valid bits and all config
// registers; the tanh table is constant logic and needs no fill
// ----------------------------------------------------------------------------
// suspension_strut_force_core: strut spring, damper and bump stop force
// Computes strut force, body moments and bump stop region for one wheel
// corner per beat in a stall-all pipeline of 3-stage multipliers.
// ----------------------------------------------------------------------------
module suspension_strut_force_core
  import ssf_pkg::*;
#(
  parameter int FRAC_BITS        = FRAC_BITS_DEF,
  parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ssf_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ssf_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(TANH_TABLE_DEPTH + 1);
  localparam logic [63:0] TANH_Y = 64'((64'd1 << 63) / TANH_TABLE_DEPTH);
  localparam logic signed [DATA_W-1:0] FOUR = DATA_W'(64'd4 << FRAC_BITS);
  localparam int VLD_N = 28;
  localparam logic signed [DATA_W-1:0] ZERO = '0;

  // config registers
  logic                     steer_en_r;
  logic signed [DATA_W-1:0] sag_r, slope_r;
  logic signed [DATA_W-1:0] k_r, c_r, lim_r, scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_en_r <= 1'b0;
      sag_r      <= '0;
      k_r        <= '0;
      c_r        <= '0;
      lim_r      <= '0;
      scale_r    <= '0;
      slope_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_STEER_EN:    steer_en_r <= cfg_data[0];
        CFG_STATIC_SAG:  sag_r      <= cfg_data;
        CFG_SPRING_RATE: k_r        <= {1'b0, cfg_data[DATA_W-2:0]};
        CFG_DAMP_RATE:   c_r        <= {1'b0, cfg_data[DATA_W-2:0]};
        CFG_TRAVEL_LIM:  lim_r      <= {1'b0, cfg_data[DATA_W-2:0]};
        CFG_STOP_SCALE:  scale_r    <= {1'b0, cfg_data[DATA_W-2:0]};
        CFG_STEER_SLOPE: slope_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  logic out_valid_r;
  logic [VLD_N-1:0] vld_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[VLD_N-2:0], in_valid};
      out_valid_r <= vld_r[VLD_N-1];
    end
  end

  // tanh table
  logic [DATA_W-1:0] tanh_rom [0:TANH_TABLE_DEPTH];
  for (genvar g = 0; g <= TANH_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [DATA_W-1:0] TV = tanh_entry(FRAC_BITS, TANH_Y, g);
    assign tanh_rom[g] = TV;
  end

  // stage 1: input differences and steer magnitude
  logic signed [DATA_W-1:0] ang1_r, dh1_r, xdot1_r, slope1_r;
  ssf_in_t in1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ang1_r   <= in_data.steer_angle[DATA_W-1] ? sat_sub(ZERO, in_data.steer_angle)
                                                : in_data.steer_angle;
      dh1_r    <= sat_sub(in_data.wheel_height, in_data.body_height);
      xdot1_r  <= sat_sub(in_data.body_vert_speed, in_data.wheel_vert_speed);
      slope1_r <= steer_en_r ? slope_r : ZERO;
      in1_r    <= in_data;
    end
  end

  // steer lift, stages 2-4
  logic signed [DATA_W-1:0] lift4, dh4, wr5;
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_lift (
    .clk(clk), .en(en), .a(ang1_r), .b(slope1_r), .q(lift4));
  ssf_dly #(.W(DATA_W), .N(3)) u_dly_dh (.clk(clk), .en(en), .d(dh1_r), .q(dh4));
  ssf_dly #(.W(DATA_W), .N(4)) u_dly_wr (
    .clk(clk), .en(en), .d(in1_r.wheel_radius), .q(wr5));

  // stage 5: body-to-wheel height
  logic signed [DATA_W-1:0] veh5_r;
  always_ff @(posedge clk) begin
    if (en) veh5_r <= sat_sub(dh4, lift4);
  end

  // stage 6: compression and lever arm
  logic signed [DATA_W-1:0] x6_r, arm6_r, xdot6;
  logic signed [DATA_W-1:0] fx6, fy6, mx9, my9, mz28;
  always_ff @(posedge clk) begin
    if (en) begin
      x6_r   <= sat_sub(sag_r, veh5_r);
      arm6_r <= sat_add(veh5_r, wr5);
    end
  end
  ssf_dly #(.W(DATA_W), .N(5)) u_dly_xdot6 (.clk(clk), .en(en), .d(xdot1_r), .q(xdot6));
  ssf_dly #(.W(DATA_W), .N(5)) u_dly_fx (
    .clk(clk), .en(en), .d(in1_r.wheel_long_force), .q(fx6));
  ssf_dly #(.W(DATA_W), .N(5)) u_dly_fy (
    .clk(clk), .en(en), .d(in1_r.wheel_lat_force), .q(fy6));
  ssf_dly #(.W(DATA_W), .N(8)) u_dly_mx (
    .clk(clk), .en(en), .d(in1_r.wheel_roll_moment), .q(mx9));
  ssf_dly #(.W(DATA_W), .N(8)) u_dly_my (
    .clk(clk), .en(en), .d(in1_r.wheel_pitch_moment), .q(my9));
  ssf_dly #(.W(DATA_W), .N(27)) u_dly_mz (
    .clk(clk), .en(en), .d(in1_r.wheel_yaw_moment), .q(mz28));

  // stage 7: stop region and penetration
  logic signed [DATA_W-1:0] xmh, xph, p7_r;
  logic [1:0] region7_r;
  always_comb begin
    xmh = sat_sub(x6_r, lim_r);
    xph = sat_add(x6_r, lim_r);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (xmh > ZERO) begin
        region7_r <= REGION_UPPER;
        p7_r      <= xmh;
      end else if (xph < ZERO) begin
        region7_r <= REGION_LOWER;
        p7_r      <= xph;
      end else begin
        region7_r <= REGION_FREE;
        p7_r      <= ZERO;
      end
    end
  end

  // base spring and damper force and moments, stages 7-10
  logic signed [DATA_W-1:0] kx9, cv9, lat9, lon9;
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_kx (
    .clk(clk), .en(en), .a(x6_r), .b(k_r), .q(kx9));
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_cv (
    .clk(clk), .en(en), .a(xdot6), .b(c_r), .q(cv9));
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_lat (
    .clk(clk), .en(en), .a(fy6), .b(arm6_r), .q(lat9));
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_lon (
    .clk(clk), .en(en), .a(fx6), .b(arm6_r), .q(lon9));

  logic signed [DATA_W-1:0] base10_r, roll10_r, pitch10_r;
  always_ff @(posedge clk) begin
    if (en) begin
      base10_r  <= sat_add(kx9, cv9);
      roll10_r  <= sat_sub(mx9, lat9);
      pitch10_r <= sat_add(lon9, my9);
    end
  end

  // scaled penetration, stages 8-10
  logic signed [DATA_W-1:0] sraw10;
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_scale (
    .clk(clk), .en(en), .a(scale_r), .b(p7_r), .q(sraw10));

  // stage 11: clamp to four
  logic signed [DATA_W:0]   smag;
  logic signed [DATA_W-1:0] s11_r;
  always_comb begin
    smag = sraw10[DATA_W-1] ? -{sraw10[DATA_W-1], sraw10} : {sraw10[DATA_W-1], sraw10};
  end
  always_ff @(posedge clk) begin
    if (en) s11_r <= (smag > {FOUR[DATA_W-1], FOUR}) ? FOUR : smag[DATA_W-1:0];
  end

  // stage 12: table lookup
  logic [63:0]      idx_sum;
  logic [63:0]      idx_full;
  logic [IDX_W-1:0] idx;
  logic signed [DATA_W-1:0] t12_r;
  always_comb begin
    idx_sum  = {16'd0, s11_r} * 64'(TANH_TABLE_DEPTH) + (64'd1 << (FRAC_BITS + 1));
    idx_full = idx_sum >> (FRAC_BITS + 2);
    idx      = (idx_full > 64'(TANH_TABLE_DEPTH)) ? IDX_W'(TANH_TABLE_DEPTH)
                                                  : idx_full[IDX_W-1:0];
  end
  always_ff @(posedge clk) begin
    if (en) t12_r <= tanh_rom[idx];
  end

  // bump stop spring path
  logic signed [DATA_W-1:0] sq14, s14, s3_17, t17, ts20, tsk23, p23, stk26;
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_sq (
    .clk(clk), .en(en), .a(s11_r), .b(s11_r), .q(sq14));
  ssf_dly #(.W(DATA_W), .N(3)) u_dly_s (.clk(clk), .en(en), .d(s11_r), .q(s14));
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_cube (
    .clk(clk), .en(en), .a(sq14), .b(s14), .q(s3_17));
  ssf_dly #(.W(DATA_W), .N(5)) u_dly_t (.clk(clk), .en(en), .d(t12_r), .q(t17));
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_ts (
    .clk(clk), .en(en), .a(t17), .b(s3_17), .q(ts20));
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_tsk (
    .clk(clk), .en(en), .a(ts20), .b(k_r), .q(tsk23));
  ssf_dly #(.W(DATA_W), .N(16)) u_dly_p (.clk(clk), .en(en), .d(p7_r), .q(p23));
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_stk (
    .clk(clk), .en(en), .a(tsk23), .b(p23), .q(stk26));

  // bump stop damper path
  logic signed [DATA_W-1:0] tc15, xdot15, stc18, stc26;
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_tc (
    .clk(clk), .en(en), .a(t12_r), .b(c_r), .q(tc15));
  ssf_dly #(.W(DATA_W), .N(9)) u_dly_xdot15 (.clk(clk), .en(en), .d(xdot6), .q(xdot15));
  ssf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_stc (
    .clk(clk), .en(en), .a(tc15), .b(xdot15), .q(stc18));
  ssf_dly #(.W(DATA_W), .N(8)) u_dly_stc (.clk(clk), .en(en), .d(stc18), .q(stc26));

  // stage 27: bump stop force, zero when free
  logic [1:0] region26, region28;
  logic signed [DATA_W-1:0] stop27_r, base27;
  ssf_dly #(.W(2), .N(19)) u_dly_reg26 (.clk(clk), .en(en), .d(region7_r), .q(region26));
  ssf_dly #(.W(2), .N(2)) u_dly_reg28 (.clk(clk), .en(en), .d(region26), .q(region28));
  ssf_dly #(.W(DATA_W), .N(17)) u_dly_base (.clk(clk), .en(en), .d(base10_r), .q(base27));
  always_ff @(posedge clk) begin
    if (en) stop27_r <= (region26 != REGION_FREE) ? sat_add(stk26, stc26) : ZERO;
  end

  // stage 28: total strut force
  logic signed [DATA_W-1:0] total28_r, roll28, pitch28;
  ssf_dly #(.W(DATA_W), .N(18)) u_dly_roll (.clk(clk), .en(en), .d(roll10_r), .q(roll28));
  ssf_dly #(.W(DATA_W), .N(18)) u_dly_pitch (.clk(clk), .en(en), .d(pitch10_r), .q(pitch28));
  always_ff @(posedge clk) begin
    if (en) total28_r <= sat_add(base27, stop27_r);
  end

  // stage 29: output register
  ssf_out_t out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.body_vert_force   <= sat_sub(ZERO, total28_r);
      out_r.wheel_vert_force  <= total28_r;
      out_r.body_roll_moment  <= roll28;
      out_r.body_pitch_moment <= pitch28;
      out_r.body_yaw_moment   <= mz28;
      out_r.stop_region       <= region28;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== tb/tb_suspension_strut_force_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_suspension_strut_force_core: self-checking bench for the strut force core
// Drives corner beats with random gaps and output stalls, predicts each result
// with a bit-exact fixed-point model and compares it field by field.
// ----------------------------------------------------------------------------
module tb_suspension_strut_force_core;
  import ssf_pkg::*;

  localparam int FB    = 24;
  localparam int DEPTH = 256;
  localparam int LIMIT = 4000;

  // register index past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef logic signed [47:0] q_t;

  // configuration copy held by the predictor
  typedef struct {
    logic steer_en;
    q_t   sag;
    q_t   k_spring;
    q_t   c_damp;
    q_t   travel;
    q_t   scale;
    q_t   slope;
  } strut_cfg_t;

  // tanh table built the same way as the hardware rom
  q_t tanh_lut [0:DEPTH];

  function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  task automatic build_tanh_lut();
    logic [63:0] y, term, r, e, num, den, rem, q;
    y = (64'd1 << 63) / DEPTH;
    term = 64'd1 << 60;
    r = term;
    e = term;
    for (int n = 1; n <= 24; n++) begin
      term = q60_mul(term, y) / n;
      if (n % 2) r = r - term;
      else r = r + term;
    end
    for (int i = 0; i <= DEPTH; i++) begin
      num = (64'd1 << 60) - e;
      den = (64'd1 << 60) + e;
      rem = num;
      q = 0;
      for (int k = 0; k < FB; k++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q[0] = 1'b1;
        end
      end
      tanh_lut[i] = q[47:0];
      e = q60_mul(e, r);
    end
  endtask

  function automatic q_t clamp(logic signed [63:0] v);
    if (v > 64'sh7fff_ffff_ffff) return 48'sh7fff_ffff_ffff;
    if (v < -64'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  // exact product, round half away from zero, saturate
  function automatic q_t qmul(q_t a, q_t b);
    logic        neg;
    logic [47:0] ua, ub;
    logic [95:0] p;
    logic [71:0] m;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = {48'd0, ua} * {48'd0, ub};
    p = p + (96'd1 << (FB - 1));
    m = p >> FB;
    if (neg) begin
      if (m > 72'h8000_0000_0000) m = 72'h8000_0000_0000;
      return -$signed({1'b0, m[47:0]});
    end
    if (m > 72'h7fff_ffff_ffff) m = 72'h7fff_ffff_ffff;
    return m[47:0];
  endfunction

  function automatic q_t qadd(q_t a, q_t b);
    return clamp(64'(a) + 64'(b));
  endfunction

  function automatic q_t qsub(q_t a, q_t b);
    return clamp(64'(a) - 64'(b));
  endfunction

  function automatic q_t bump_force(strut_cfg_t c, q_t p, q_t xdot);
    q_t s, t, s3;
    logic signed [63:0] idx;
    logic signed [63:0] smag;
    q_t four;
    four = 48'sd4 << FB;
    s = qmul(c.scale, p);
    // magnitude taken wide so the most negative product clamps to four
    smag = 64'(s);
    if (smag < 0) smag = -smag;
    if (smag > 64'(four)) smag = 64'(four);
    s = smag[47:0];
    idx = (64'(s) * DEPTH + (64'sd2 << FB)) / 64'(four);
    if (idx > DEPTH) idx = DEPTH;
    t = tanh_lut[idx];
    s3 = qmul(qmul(s, s), s);
    return clamp(64'(qmul(qmul(qmul(t, s3), c.k_spring), p)) +
                 64'(qmul(qmul(t, c.c_damp), xdot)));
  endfunction

  function automatic ssf_out_t strut_predict(strut_cfg_t c, ssf_in_t d);
    ssf_out_t r;
    q_t ang, slope, veh_h, x, xdot, xmh, xph, stop, total, arm;
    ang = d.steer_angle < 0 ? clamp(-64'(d.steer_angle)) : d.steer_angle;
    slope = c.steer_en ? c.slope : '0;
    veh_h = qsub(qsub(d.wheel_height, d.body_height), qmul(ang, slope));
    x = qsub(c.sag, veh_h);
    xdot = qsub(d.body_vert_speed, d.wheel_vert_speed);
    xmh = qsub(x, c.travel);
    xph = qadd(x, c.travel);
    stop = '0;
    r.stop_region = REGION_FREE;
    if (xmh > 0) begin
      r.stop_region = REGION_UPPER;
      stop = bump_force(c, xmh, xdot);
    end else if (xph < 0) begin
      r.stop_region = REGION_LOWER;
      stop = bump_force(c, xph, xdot);
    end
    total = qadd(qadd(qmul(x, c.k_spring), qmul(xdot, c.c_damp)), stop);
    arm = qadd(veh_h, d.wheel_radius);
    r.body_vert_force = clamp(-64'(total));
    r.wheel_vert_force = total;
    r.body_roll_moment = qsub(d.wheel_roll_moment, qmul(d.wheel_lat_force, arm));
    r.body_pitch_moment = qadd(qmul(d.wheel_long_force, arm), d.wheel_pitch_moment);
    r.body_yaw_moment = d.wheel_yaw_moment;
    return r;
  endfunction

  int mismatches = 0;

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // scoreboard holding pending strut results
  class strut_scoreboard;
    strut_cfg_t cfg;
    ssf_out_t   pending[$];

    function void note_corner(ssf_in_t d);
      pending.push_back(strut_predict(cfg, d));
    endfunction

    task check_result(ssf_out_t got);
      ssf_out_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected beat", got.wheel_vert_force, '0);
        return;
      end
      w = pending.pop_front();
      if (got.body_vert_force !== w.body_vert_force)
        report_mismatch("body_vert_force", got.body_vert_force, w.body_vert_force);
      if (got.wheel_vert_force !== w.wheel_vert_force)
        report_mismatch("wheel_vert_force", got.wheel_vert_force, w.wheel_vert_force);
      if (got.body_roll_moment !== w.body_roll_moment)
        report_mismatch("body_roll_moment", got.body_roll_moment, w.body_roll_moment);
      if (got.body_pitch_moment !== w.body_pitch_moment)
        report_mismatch("body_pitch_moment", got.body_pitch_moment, w.body_pitch_moment);
      if (got.body_yaw_moment !== w.body_yaw_moment)
        report_mismatch("body_yaw_moment", got.body_yaw_moment, w.body_yaw_moment);
      if (got.stop_region !== w.stop_region)
        report_mismatch("stop_region", 48'(got.stop_region), 48'(w.stop_region));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ssf_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ssf_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  strut_scoreboard sb;
  logic idle_gaps = 1'b1;
  logic hold_off = 1'b0;
  int   quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  suspension_strut_force_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall bursts, plus one long hold-off
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_gaps && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      CFG_STEER_EN:    sb.cfg.steer_en = val[0];
      CFG_STATIC_SAG:  sb.cfg.sag = val;
      CFG_SPRING_RATE: sb.cfg.k_spring = {1'b0, val[46:0]};
      CFG_DAMP_RATE:   sb.cfg.c_damp = {1'b0, val[46:0]};
      CFG_TRAVEL_LIM:  sb.cfg.travel = {1'b0, val[46:0]};
      CFG_STOP_SCALE:  sb.cfg.scale = {1'b0, val[46:0]};
      CFG_STEER_SLOPE: sb.cfg.slope = val;
      default: ;
    endcase
  endtask

  // drop the write enable after a run of register writes
  task automatic end_writes();
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_corner(ssf_in_t d);
    int n;
    if (idle_gaps && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_corner(d);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic q_t rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // value near a working scale, sometimes extreme
  function automatic q_t rand_phys(int mag);
    case ($urandom_range(0, 9))
      0: return 48'sh7fff_ffff_ffff;
      1: return 48'sh8000_0000_0000;
      2: return rand48();
      default: return $signed(48'($urandom_range(0, 1 << mag))) - (48'sd1 << (mag - 1));
    endcase
  endfunction

  function automatic ssf_in_t rand_corner();
    ssf_in_t d;
    d.wheel_height = rand_phys(26);
    d.wheel_radius = rand_phys(25);
    d.wheel_vert_speed = rand_phys(26);
    d.wheel_long_force = rand_phys(30);
    d.wheel_lat_force = rand_phys(30);
    d.wheel_roll_moment = rand_phys(30);
    d.wheel_pitch_moment = rand_phys(30);
    d.wheel_yaw_moment = rand48();
    d.body_height = rand_phys(26);
    d.body_vert_speed = rand_phys(26);
    d.steer_angle = rand_phys(25);
    return d;
  endfunction

  task automatic apply_setting(logic [47:0] sag, logic [47:0] k, logic [47:0] c,
                               logic [47:0] lim, logic [47:0] sc, logic [47:0] sl,
                               logic en);
    write_reg(CFG_STEER_EN, {47'd0, en});
    write_reg(CFG_STATIC_SAG, sag);
    write_reg(CFG_SPRING_RATE, k);
    write_reg(CFG_DAMP_RATE, c);
    write_reg(CFG_TRAVEL_LIM, lim);
    write_reg(CFG_STOP_SCALE, sc);
    write_reg(CFG_STEER_SLOPE, sl);
    end_writes();
  endtask

  initial begin
    ssf_in_t d;
    sb = new();
    sb.cfg = '{1'b0, '0, '0, '0, '0, '0, '0};
    build_tanh_lut();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset config, then a typical strut with a narrow travel
    send_corner('0);
    drain();
    apply_setting(48'sd1 << 22, 48'd20000 << FB, 48'd1500 << FB, 48'd1 << 21,
                  48'd640 << FB, 48'hffff_ff00_0000, 1'b1);
    write_reg(CFG_UNUSED, rand48());
    end_writes();
    d = '0;
    send_corner(d);
    d = '1;
    send_corner(d);
    d = {11{48'sh7fff_ffff_ffff}};
    send_corner(d);
    d = {11{48'sh8000_0000_0000}};
    send_corner(d);
    // deep compression, extension, just inside travel
    d = '0;
    d.body_height = 48'sd1 << 23;
    send_corner(d);
    d.body_height = -(48'sd1 << 23);
    d.body_vert_speed = 48'sd3 << 24;
    send_corner(d);
    d.body_height = -(48'sd1 << 21);
    send_corner(d);
    d = '0;
    d.steer_angle = 48'sh8000_0000_0000;
    send_corner(d);
    drain();

    // zero stop scale and zero travel limit
    apply_setting(48'sd0, 48'd5000 << FB, 48'd800 << FB, 48'd0, 48'd0, 48'sd1 << 22, 1'b0);
    d = '0;
    send_corner(d);
    d.wheel_height = 48'sd1;
    send_corner(d);
    d.wheel_height = -48'sd1;
    send_corner(d);
    drain();

    // random phases over several register settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_setting(48'sd1 << 22, 48'd30000 << FB, 48'd2000 << FB, 48'd1 << 22,
                         48'd320 << FB, 48'sd1 << 20, 1'b1);
        1: apply_setting(48'sh7fff_ffff_ffff, 48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff,
                         48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff, 48'sh7fff_ffff_ffff, 1'b1);
        2: apply_setting(48'sh8000_0000_0000, 48'hffff_ffff_ffff, 48'd0, 48'd0,
                         48'h7fff_ffff_ffff, 48'sh8000_0000_0000, 1'b1);
        3: apply_setting(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), 1'b0);
        default: apply_setting(rand_phys(24), 48'($urandom_range(1, 1 << 30)) << 10,
                               48'($urandom_range(0, 1 << 26)) << 8,
                               48'($urandom_range(1, 1 << 23)),
                               48'($urandom_range(0, 1 << 30)) << 4,
                               rand_phys(24), 1'($urandom));
      endcase
      if (ph == 2) hold_off = 1'b1;
      if (ph == 5) idle_gaps = 1'b0;
      repeat (90) send_corner(rand_corner());
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
